FILE: rtl/core/mma_pkg.sv
// Shared types, codes and helpers of the Montgomery modular ALU.
`timescale 1ns / 1ps
package mma_pkg;

  localparam int unsigned MOD_W  = 30;
  localparam int unsigned MONT_W = 32;
  localparam int unsigned VAL_W  = 31;

  localparam logic [MOD_W-1:0] RESET_MODULUS = 30'd1000000007;

  localparam logic [3:0] FN_FROM_INT = 4'd0;
  localparam logic [3:0] FN_TO_INT   = 4'd1;
  localparam logic [3:0] FN_NEG      = 4'd2;
  localparam logic [3:0] FN_ADD      = 4'd3;
  localparam logic [3:0] FN_SUB      = 4'd4;
  localparam logic [3:0] FN_MUL      = 4'd5;
  localparam logic [3:0] FN_INV      = 4'd6;
  localparam logic [3:0] FN_DIV      = 4'd7;
  localparam logic [3:0] FN_EQ       = 4'd8;
  localparam logic [3:0] FN_LT       = 4'd9;
  localparam logic [3:0] FN_IS_ZERO  = 4'd10;

  typedef struct packed {
    logic [3:0]        func;
    logic [VAL_W-1:0]  operand_a;
    logic [VAL_W-1:0]  operand_b;
    logic signed [63:0] plain_value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             flag;
  } out_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CFG_WR, OP_CAPTURE, OP_DRV_INIT, OP_DRV_MUL1, OP_DRV_MUL2,
    OP_DRV_UPD, OP_DIV_SQ, OP_DRV_END, OP_RD_A, OP_RD_B, OP_RD_C, OP_ACC_A,
    OP_ACC_INVSRC, OP_MUL_AB, OP_NORM_RES, OP_LT_B, OP_LT_CMP, OP_SIMPLE,
    OP_LOAD_MAG_PV, OP_DIV_MAG, OP_FS_T, OP_FS_MUL, OP_EU_INIT, OP_DIV_EU,
    OP_EU_MUL, OP_EU_UPD, OP_LOAD_MAG_C1, OP_DV_MUL, OP_OUT_LOAD
  } op_t;

  typedef enum logic [4:0] {
    ST_DRV_INIT, ST_DRV_MUL1, ST_DRV_MUL2, ST_DRV_UPD, ST_DRV_SQ, ST_DRV_SQW,
    ST_DRV_END, ST_IDLE, ST_DISP, ST_RD_A, ST_RD_B, ST_RD_C, ST_TI_NORM,
    ST_LT_B, ST_LT_CMP, ST_FS_DIV, ST_FS_WAIT, ST_FS_T, ST_FS_MUL, ST_EU_INIT,
    ST_EU_CHK, ST_EU_WAIT, ST_EU_MUL, ST_EU_UPD, ST_EU_FIN, ST_DV_MUL, ST_FIN
  } st_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       div_busy;
    logic       ey_zero;
  } dp_stat_t;

  // Lazy reduction: subtract m once when x is at least m (32-bit wrap).
  function automatic logic [MONT_W-1:0] norm_res(input logic [MONT_W-1:0] x,
                                                 input logic [MOD_W-1:0] m);
    logic [MONT_W-1:0] d;
    d = {2'b00, m} - 32'd1 - x;
    return d[MONT_W-1] ? x - {2'b00, m} : x;
  endfunction

endpackage

FILE: rtl/core/mma_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit or 32-bit dividend.
`timescale 1ns / 1ps
module mma_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        long_mode,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [32:0] r_sh, r_sub;
  logic        ge;

  assign busy      = (cnt_r != 7'd0);
  assign quotient  = dvd_r[31:0];
  assign remainder = rem_r;

  always_comb begin
    r_sh    = {rem_r, dvd_r[63]};
    r_sub   = r_sh - {1'b0, dsr_r};
    ge      = (r_sh >= {1'b0, dsr_r});
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    if (start) begin
      dvd_nxt = long_mode ? dividend : {dividend[31:0], 32'd0};
      rem_nxt = 32'd0;
      dsr_nxt = divisor;
      cnt_nxt = long_mode ? 7'd64 : 7'd32;
    end else if (busy) begin
      rem_nxt = ge ? r_sub[31:0] : r_sh[31:0];
      dvd_nxt = {dvd_r[62:0], ge};
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 7'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

FILE: rtl/core/mma_dp.sv
// Datapath: modulus and derived constants, shared multiplier, Euclid registers.
`timescale 1ns / 1ps
module mma_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mma_pkg::dp_cmd_t           cmd,
  output mma_pkg::dp_stat_t          stat,
  input  mma_pkg::in_t               in_data,
  input  logic [mma_pkg::MOD_W-1:0]  cfg_data,
  output mma_pkg::out_t              out_data
);

  logic [29:0] m_r, m_nxt;
  logic [31:0] ninv_r, ninv_nxt;
  logic [29:0] sq_r, sq_nxt;
  logic [3:0]  func_r, func_nxt;
  logic [30:0] a_r, a_nxt, b_r, b_nxt;
  logic [63:0] pv_r, pv_nxt;
  logic [63:0] acc_r, acc_nxt, prod_r, prod_nxt;
  logic [31:0] t_r, t_nxt, res_r, res_nxt, pa_r, pa_nxt;
  logic        flag_r, flag_nxt, neg_r, neg_nxt;
  logic [31:0] ex_r, ex_nxt, ey_r, ey_nxt, c1_r, c1_nxt, c3_r, c3_nxt;
  logic [63:0] mag_r, mag_nxt;
  mma_pkg::out_t out_r, out_nxt;

  logic [31:0] mul_x, mul_y;
  logic [63:0] product, redc_sum;
  logic [31:0] m32, m2, a32, b32, na, nb, tmp, mc1;
  logic        div_start, div_long, div_busy;
  logic [63:0] div_dvd;
  logic [31:0] div_dsr, div_quo, div_rem;

  mma_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .long_mode (div_long),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign m32 = {2'b00, m_r};
  assign m2  = {1'b0, m_r, 1'b0};
  assign a32 = {1'b0, a_r};
  assign b32 = {1'b0, b_r};

  assign stat.func     = func_r;
  assign stat.div_busy = div_busy;
  assign stat.ey_zero  = (ey_r == 32'd0);
  assign out_data      = out_r;

  // Operand selection for the one 32x32 multiplier.
  always_comb begin
    mul_x = 32'd0;
    mul_y = 32'd0;
    case (cmd.op)
      mma_pkg::OP_DRV_MUL1: begin mul_x = m32;          mul_y = t_r; end
      mma_pkg::OP_DRV_MUL2: begin mul_x = t_r;          mul_y = 32'd2 - prod_r[31:0]; end
      mma_pkg::OP_RD_A:     begin mul_x = acc_r[31:0];  mul_y = ninv_r; end
      mma_pkg::OP_RD_B:     begin mul_x = prod_r[31:0]; mul_y = m32; end
      mma_pkg::OP_FS_MUL:   begin mul_x = t_r;          mul_y = {2'b00, sq_r}; end
      mma_pkg::OP_MUL_AB:   begin mul_x = a32;          mul_y = b32; end
      mma_pkg::OP_DV_MUL:   begin mul_x = a32;          mul_y = res_r; end
      mma_pkg::OP_EU_MUL:   begin mul_x = c3_r;         mul_y = div_quo; end
      default: begin end
    endcase
    product = mul_x * mul_y;
  end

  // Divider start and operand selection.
  always_comb begin
    div_start = 1'b0;
    div_long  = 1'b1;
    div_dvd   = mag_r;
    div_dsr   = m32;
    case (cmd.op)
      mma_pkg::OP_DIV_SQ: begin
        div_start = 1'b1;
        div_dvd   = 64'd0 - {34'd0, m_r};
      end
      mma_pkg::OP_DIV_MAG: begin
        div_start = 1'b1;
      end
      mma_pkg::OP_DIV_EU: begin
        div_start = 1'b1;
        div_long  = 1'b0;
        div_dvd   = {32'd0, ex_r};
        div_dsr   = ey_r;
      end
      default: begin end
    endcase
  end

  always_comb begin
    m_nxt    = m_r;    ninv_nxt = ninv_r; sq_nxt   = sq_r;
    func_nxt = func_r; a_nxt    = a_r;    b_nxt    = b_r;   pv_nxt = pv_r;
    acc_nxt  = acc_r;  prod_nxt = prod_r; t_nxt    = t_r;
    res_nxt  = res_r;  pa_nxt   = pa_r;   flag_nxt = flag_r; neg_nxt = neg_r;
    ex_nxt   = ex_r;   ey_nxt   = ey_r;   c1_nxt   = c1_r;  c3_nxt = c3_r;
    mag_nxt  = mag_r;  out_nxt  = out_r;
    redc_sum = acc_r + prod_r;
    na       = mma_pkg::norm_res(a32, m_r);
    nb       = mma_pkg::norm_res(b32, m_r);
    tmp      = 32'd0;
    mc1      = 32'd0 - c1_r;
    case (cmd.op)
      mma_pkg::OP_CFG_WR: begin
        if (cfg_data[0] && (cfg_data >= 30'd3)) begin
          m_nxt = cfg_data;
        end
      end
      mma_pkg::OP_CAPTURE: begin
        func_nxt = in_data.func;
        a_nxt    = in_data.operand_a;
        b_nxt    = in_data.operand_b;
        pv_nxt   = in_data.plain_value;
        flag_nxt = 1'b0;
        res_nxt  = 32'd0;
      end
      mma_pkg::OP_DRV_INIT: t_nxt    = m32;
      mma_pkg::OP_DRV_MUL1: prod_nxt = product;
      mma_pkg::OP_DRV_MUL2: prod_nxt = product;
      mma_pkg::OP_DRV_UPD:  t_nxt    = prod_r[31:0];
      mma_pkg::OP_DRV_END: begin
        ninv_nxt = 32'd0 - t_r;
        sq_nxt   = div_rem[29:0];
      end
      mma_pkg::OP_RD_A:       prod_nxt = product;
      mma_pkg::OP_RD_B:       prod_nxt = product;
      mma_pkg::OP_RD_C:       res_nxt  = redc_sum[63:32];
      mma_pkg::OP_ACC_A:      acc_nxt  = {33'd0, a_r};
      mma_pkg::OP_ACC_INVSRC: acc_nxt  = (func_r == mma_pkg::FN_DIV) ? {33'd0, b_r}
                                                                      : {33'd0, a_r};
      mma_pkg::OP_MUL_AB:     acc_nxt  = product;
      mma_pkg::OP_DV_MUL:     acc_nxt  = product;
      mma_pkg::OP_FS_MUL:     acc_nxt  = product;
      mma_pkg::OP_NORM_RES:   res_nxt  = mma_pkg::norm_res(res_r, m_r);
      mma_pkg::OP_LT_B: begin
        pa_nxt  = mma_pkg::norm_res(res_r, m_r);
        acc_nxt = {33'd0, b_r};
      end
      mma_pkg::OP_LT_CMP: begin
        flag_nxt = (pa_r < mma_pkg::norm_res(res_r, m_r));
        res_nxt  = 32'd0;
      end
      mma_pkg::OP_SIMPLE: begin
        case (func_r)
          mma_pkg::FN_NEG: res_nxt = ((a_r != 31'd0) ? m2 : 32'd0) - a32;
          mma_pkg::FN_ADD: begin
            tmp     = a32 + b32 - m2;
            res_nxt = tmp + (tmp[31] ? m2 : 32'd0);
          end
          mma_pkg::FN_SUB: begin
            tmp     = a32 - b32;
            res_nxt = tmp + (tmp[31] ? m2 : 32'd0);
          end
          mma_pkg::FN_EQ:      flag_nxt = (na == nb);
          mma_pkg::FN_IS_ZERO: flag_nxt = (a32 == 32'd0) || (a32 == m32);
          default: begin end
        endcase
      end
      mma_pkg::OP_LOAD_MAG_PV: begin
        neg_nxt = pv_r[63];
        mag_nxt = pv_r[63] ? 64'd0 - pv_r : pv_r;
      end
      mma_pkg::OP_LOAD_MAG_C1: begin
        neg_nxt = c1_r[31];
        mag_nxt = {32'd0, c1_r[31] ? mc1 : c1_r};
      end
      mma_pkg::OP_FS_T: t_nxt = neg_r ? m32 - div_rem : div_rem + m32;
      mma_pkg::OP_EU_INIT: begin
        ex_nxt = mma_pkg::norm_res(res_r, m_r);
        ey_nxt = m32;
        c1_nxt = 32'd1;
        c3_nxt = 32'd0;
      end
      mma_pkg::OP_EU_MUL: prod_nxt = product;
      mma_pkg::OP_EU_UPD: begin
        c1_nxt = c3_r;
        c3_nxt = c1_r - prod_r[31:0];
        ex_nxt = ey_r;
        ey_nxt = div_rem;
      end
      mma_pkg::OP_OUT_LOAD: begin
        out_nxt.value = res_r[30:0];
        out_nxt.flag  = flag_r;
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= mma_pkg::RESET_MODULUS;
    end else begin
      m_r <= m_nxt;
    end
    ninv_r <= ninv_nxt; sq_r  <= sq_nxt;   func_r <= func_nxt;
    a_r    <= a_nxt;    b_r   <= b_nxt;    pv_r   <= pv_nxt;
    acc_r  <= acc_nxt;  prod_r <= prod_nxt; t_r   <= t_nxt;
    res_r  <= res_nxt;  pa_r  <= pa_nxt;   flag_r <= flag_nxt;
    neg_r  <= neg_nxt;  ex_r  <= ex_nxt;   ey_r   <= ey_nxt;
    c1_r   <= c1_nxt;   c3_r  <= c3_nxt;   mag_r  <= mag_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: rtl/core/mma_ctrl.sv
// Controller state machine sequencing the datapath for each operation.
`timescale 1ns / 1ps
module mma_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mma_pkg::dp_stat_t  stat,
  output mma_pkg::dp_cmd_t   cmd
);

  mma_pkg::st_t st_r, st_nxt, ret_r, ret_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign cfg_ready = (st_r == mma_pkg::ST_IDLE);
  assign in_stall  = (st_r != mma_pkg::ST_IDLE) || cfg_valid;

  // Next state.
  always_comb begin
    st_nxt  = st_r;
    ret_nxt = ret_r;
    cnt_nxt = cnt_r;
    case (st_r)
      mma_pkg::ST_DRV_INIT: begin
        cnt_nxt = 3'd0;
        st_nxt  = mma_pkg::ST_DRV_MUL1;
      end
      mma_pkg::ST_DRV_MUL1: st_nxt = mma_pkg::ST_DRV_MUL2;
      mma_pkg::ST_DRV_MUL2: st_nxt = mma_pkg::ST_DRV_UPD;
      mma_pkg::ST_DRV_UPD: begin
        cnt_nxt = cnt_r + 3'd1;
        st_nxt  = (cnt_r == 3'd4) ? mma_pkg::ST_DRV_SQ : mma_pkg::ST_DRV_MUL1;
      end
      mma_pkg::ST_DRV_SQ:  st_nxt = mma_pkg::ST_DRV_SQW;
      mma_pkg::ST_DRV_SQW: if (!stat.div_busy) st_nxt = mma_pkg::ST_DRV_END;
      mma_pkg::ST_DRV_END: st_nxt = mma_pkg::ST_IDLE;
      mma_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          st_nxt = mma_pkg::ST_DRV_INIT;
        end else if (in_valid) begin
          st_nxt = mma_pkg::ST_DISP;
        end
      end
      mma_pkg::ST_DISP: begin
        st_nxt = mma_pkg::ST_RD_A;
        case (stat.func)
          mma_pkg::FN_FROM_INT: st_nxt = mma_pkg::ST_FS_DIV;
          mma_pkg::FN_TO_INT:   ret_nxt = mma_pkg::ST_TI_NORM;
          mma_pkg::FN_MUL:      ret_nxt = mma_pkg::ST_FIN;
          mma_pkg::FN_INV,
          mma_pkg::FN_DIV:      ret_nxt = mma_pkg::ST_EU_INIT;
          mma_pkg::FN_LT:       ret_nxt = mma_pkg::ST_LT_B;
          default:              st_nxt = mma_pkg::ST_FIN;
        endcase
      end
      mma_pkg::ST_RD_A:    st_nxt = mma_pkg::ST_RD_B;
      mma_pkg::ST_RD_B:    st_nxt = mma_pkg::ST_RD_C;
      mma_pkg::ST_RD_C:    st_nxt = ret_r;
      mma_pkg::ST_TI_NORM: st_nxt = mma_pkg::ST_FIN;
      mma_pkg::ST_LT_B: begin
        ret_nxt = mma_pkg::ST_LT_CMP;
        st_nxt  = mma_pkg::ST_RD_A;
      end
      mma_pkg::ST_LT_CMP:  st_nxt = mma_pkg::ST_FIN;
      mma_pkg::ST_FS_DIV:  st_nxt = mma_pkg::ST_FS_WAIT;
      mma_pkg::ST_FS_WAIT: if (!stat.div_busy) st_nxt = mma_pkg::ST_FS_T;
      mma_pkg::ST_FS_T:    st_nxt = mma_pkg::ST_FS_MUL;
      mma_pkg::ST_FS_MUL: begin
        ret_nxt = (stat.func == mma_pkg::FN_DIV) ? mma_pkg::ST_DV_MUL : mma_pkg::ST_FIN;
        st_nxt  = mma_pkg::ST_RD_A;
      end
      mma_pkg::ST_EU_INIT: st_nxt = mma_pkg::ST_EU_CHK;
      mma_pkg::ST_EU_CHK:  st_nxt = stat.ey_zero ? mma_pkg::ST_EU_FIN : mma_pkg::ST_EU_WAIT;
      mma_pkg::ST_EU_WAIT: if (!stat.div_busy) st_nxt = mma_pkg::ST_EU_MUL;
      mma_pkg::ST_EU_MUL:  st_nxt = mma_pkg::ST_EU_UPD;
      mma_pkg::ST_EU_UPD:  st_nxt = mma_pkg::ST_EU_CHK;
      mma_pkg::ST_EU_FIN:  st_nxt = mma_pkg::ST_FS_DIV;
      mma_pkg::ST_DV_MUL: begin
        ret_nxt = mma_pkg::ST_FIN;
        st_nxt  = mma_pkg::ST_RD_A;
      end
      mma_pkg::ST_FIN: if (out_free) st_nxt = mma_pkg::ST_IDLE;
      default: st_nxt = mma_pkg::ST_IDLE;
    endcase
  end

  // Datapath command and output beat.
  always_comb begin
    cmd.op        = mma_pkg::OP_NOP;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      mma_pkg::ST_DRV_INIT: cmd.op = mma_pkg::OP_DRV_INIT;
      mma_pkg::ST_DRV_MUL1: cmd.op = mma_pkg::OP_DRV_MUL1;
      mma_pkg::ST_DRV_MUL2: cmd.op = mma_pkg::OP_DRV_MUL2;
      mma_pkg::ST_DRV_UPD:  cmd.op = mma_pkg::OP_DRV_UPD;
      mma_pkg::ST_DRV_SQ:   cmd.op = mma_pkg::OP_DIV_SQ;
      mma_pkg::ST_DRV_END:  cmd.op = mma_pkg::OP_DRV_END;
      mma_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          cmd.op = mma_pkg::OP_CFG_WR;
        end else if (in_valid) begin
          cmd.op = mma_pkg::OP_CAPTURE;
        end
      end
      mma_pkg::ST_DISP: begin
        case (stat.func)
          mma_pkg::FN_FROM_INT: cmd.op = mma_pkg::OP_LOAD_MAG_PV;
          mma_pkg::FN_TO_INT,
          mma_pkg::FN_LT:       cmd.op = mma_pkg::OP_ACC_A;
          mma_pkg::FN_MUL:      cmd.op = mma_pkg::OP_MUL_AB;
          mma_pkg::FN_INV,
          mma_pkg::FN_DIV:      cmd.op = mma_pkg::OP_ACC_INVSRC;
          default:              cmd.op = mma_pkg::OP_SIMPLE;
        endcase
      end
      mma_pkg::ST_RD_A:    cmd.op = mma_pkg::OP_RD_A;
      mma_pkg::ST_RD_B:    cmd.op = mma_pkg::OP_RD_B;
      mma_pkg::ST_RD_C:    cmd.op = mma_pkg::OP_RD_C;
      mma_pkg::ST_TI_NORM: cmd.op = mma_pkg::OP_NORM_RES;
      mma_pkg::ST_LT_B:    cmd.op = mma_pkg::OP_LT_B;
      mma_pkg::ST_LT_CMP:  cmd.op = mma_pkg::OP_LT_CMP;
      mma_pkg::ST_FS_DIV:  cmd.op = mma_pkg::OP_DIV_MAG;
      mma_pkg::ST_FS_T:    cmd.op = mma_pkg::OP_FS_T;
      mma_pkg::ST_FS_MUL:  cmd.op = mma_pkg::OP_FS_MUL;
      mma_pkg::ST_EU_INIT: cmd.op = mma_pkg::OP_EU_INIT;
      mma_pkg::ST_EU_CHK:  if (!stat.ey_zero) cmd.op = mma_pkg::OP_DIV_EU;
      mma_pkg::ST_EU_MUL:  cmd.op = mma_pkg::OP_EU_MUL;
      mma_pkg::ST_EU_UPD:  cmd.op = mma_pkg::OP_EU_UPD;
      mma_pkg::ST_EU_FIN:  cmd.op = mma_pkg::OP_LOAD_MAG_C1;
      mma_pkg::ST_DV_MUL:  cmd.op = mma_pkg::OP_DV_MUL;
      mma_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.op        = mma_pkg::OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = mma_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mma_pkg::ST_DRV_INIT;
      ret_r       <= mma_pkg::ST_FIN;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/montgomery_modular_alu_core.sv
// Top level of the Montgomery modular ALU: controller plus datapath.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake            Beat carries
//  in_      input      in_valid / in_stall  mma_pkg::in_t (func, operands, plain value)
//  out_     output     out_valid/out_stall  mma_pkg::out_t (value, flag)
//  cfg_     input      cfg_valid/cfg_ready  30-bit modulus
//
// One item is worked on at a time. Negate, add, subtract, eq and is_zero
// are the quickest; mul, to_int and lt take longer in that order, each
// Montgomery reduction passing through the one 32x32 multiplier. from_int
// adds a bit-serial remainder from the shared divider; inv runs extended
// Euclid, each step waiting on a quotient from that divider, and div adds
// a multiply and a further reduction.
// After reset, and after each modulus write, the block derives -m^-1 mod 2^32
// and 2^64 mod m, stalling input and configuration while it does so.
// A finished result sits in the output register while the next beat is taken;
// a further result waits in its last state until that register is free.
module montgomery_modular_alu_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mma_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mma_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mma_pkg::MOD_W-1:0] cfg_data
);

  // Command and status between the sequencer and the arithmetic.
  mma_pkg::dp_cmd_t  cmd;
  mma_pkg::dp_stat_t stat;

  mma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mma_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the Montgomery modular ALU core.
`timescale 1ns / 1ps
module tb;
  import mma_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 600;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [MOD_W-1:0]  cfg_data = '0;

  montgomery_modular_alu_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor copy of the modulus and its two derived constants.
  logic [31:0] mod_m;
  logic [31:0] mod_ninv;
  logic [31:0] mod_sq;

  in_t  pending_q[$];
  out_t want_q[$];
  int   n_queued = 0;
  int   n_taken = 0;
  int   cfg_count = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   phase = 0;
  logic took = 1'b0;

  // Recomputes -m^-1 mod 2^32 by Newton iteration and 2^64 mod m.
  task automatic derive_constants();
    logic [31:0] inv;
    logic [63:0] neg_m;
    inv = mod_m;
    for (int k = 0; k < 5; k++) begin
      inv = inv * (32'd2 - mod_m * inv);
    end
    mod_ninv = 32'd0 - inv;
    neg_m = 64'd0 - {32'd0, mod_m};
    mod_sq = 32'(neg_m % {32'd0, mod_m});
  endtask

  // Modulus writes that are even or below three leave everything untouched.
  task automatic apply_modulus(input logic [MOD_W-1:0] data);
    logic [31:0] m;
    m = {2'b00, data};
    if (m[0] && m >= 32'd3) begin
      mod_m = m;
      derive_constants();
    end
  endtask

  function automatic logic [31:0] mont_reduce(input logic [63:0] x);
    logic [31:0] q;
    logic [63:0] s;
    q = x[31:0] * mod_ninv;
    s = x + {32'd0, q} * {32'd0, mod_m};
    return s[63:32];
  endfunction

  function automatic logic [31:0] lazy_norm(input logic [31:0] x);
    logic [31:0] d;
    d = mod_m - 32'd1 - x;
    return d[31] ? x - mod_m : x;
  endfunction

  function automatic logic [31:0] residue_of(input logic [31:0] a);
    return lazy_norm(mont_reduce({32'd0, a}));
  endfunction

  function automatic logic [31:0] to_mont(input logic is_neg, input logic [63:0] mag);
    logic [63:0] r;
    logic [63:0] t;
    r = mag % {32'd0, mod_m};
    t = is_neg ? {32'd0, mod_m} - r : r + {32'd0, mod_m};
    return mont_reduce(t * {32'd0, mod_sq});
  endfunction

  // Extended Euclid on the plain residue; whatever coefficient is left over
  // is converted, coprime or not.
  function automatic logic [31:0] mont_inverse(input logic [31:0] a);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] q;
    logic [63:0] rem;
    longint c1;
    longint c3;
    longint nc;
    x = {32'd0, residue_of(a)};
    y = {32'd0, mod_m};
    c1 = 1;
    c3 = 0;
    while (y != 0) begin
      q = x / y;
      rem = x - y * q;
      nc = c1 - c3 * longint'(q);
      c1 = c3;
      c3 = nc;
      x = y;
      y = rem;
    end
    if (c1 < 0) return to_mont(1'b1, 64'(-c1));
    return to_mont(1'b0, 64'(c1));
  endfunction

  function automatic out_t alu_result(input in_t it);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] m2;
    logic [31:0] t;
    logic [31:0] v;
    logic [63:0] pv;
    logic        f;
    out_t        r;
    a = {1'b0, it.operand_a};
    b = {1'b0, it.operand_b};
    pv = it.plain_value;
    m2 = mod_m << 1;
    v = '0;
    f = 1'b0;
    case (it.func)
      FN_FROM_INT: begin
        v = pv[63] ? to_mont(1'b1, 64'd0 - pv) : to_mont(1'b0, pv);
      end
      FN_TO_INT: v = residue_of(a);
      FN_NEG:    v = ((a != 0) ? m2 : 32'd0) - a;
      FN_ADD: begin
        t = a + b - m2;
        v = t[31] ? t + m2 : t;
      end
      FN_SUB: begin
        t = a - b;
        v = t[31] ? t + m2 : t;
      end
      FN_MUL:     v = mont_reduce({32'd0, a} * {32'd0, b});
      FN_INV:     v = mont_inverse(a);
      FN_DIV:     v = mont_reduce({32'd0, a} * {32'd0, mont_inverse(b)});
      FN_EQ:      f = (lazy_norm(a) == lazy_norm(b));
      FN_LT:      f = (residue_of(a) < residue_of(b));
      FN_IS_ZERO: f = (a == 0 || a == mod_m);
      default: begin
      end
    endcase
    r.value = v[VAL_W-1:0];
    r.flag = f;
    return r;
  endfunction

  // Driver: a new beat is offered only once the previous one has gone.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long hold-off on the result side at the start of the last phase, so the
  // core fills up and has to push back on its input.
  int  hold_count = 0;
  logic hold_on;
  assign hold_on = (phase == 3) && (hold_count < HOLD_CYCLES);

  always @(negedge clk) begin
    if (phase == 3 && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predicts on every accepted input beat and checks every
  // accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    out_t exp_r;
    cycles <= cycles + 1;
    took <= in_valid && !in_stall;
    if (rst_n && cfg_valid && cfg_ready) begin
      apply_modulus(cfg_data);
      cfg_count <= cfg_count + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result beat: value %0d flag %0d",
                                      out_data.value, out_data.flag);
      end else begin
        exp_r = want_q.pop_front();
        if (exp_r.value !== out_data.value || exp_r.flag !== out_data.flag) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("Mismatch: expected value %0d flag %0d, got value %0d flag %0d",
                     exp_r.value, exp_r.flag, out_data.value, out_data.flag);
          end
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      want_q.push_back(alu_result(in_data));
      n_taken <= n_taken + 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_t make_item(input logic [3:0] fn, input logic [31:0] a,
                                    input logic [31:0] b, input logic [63:0] pv);
    in_t it;
    it.func = fn;
    it.operand_a = a[VAL_W-1:0];
    it.operand_b = b[VAL_W-1:0];
    it.plain_value = pv;
    return it;
  endfunction

  // Operands are mostly well formed, below 2m, with the occasional raw
  // 31-bit pattern and the edge values thrown in.
  function automatic logic [31:0] rand_operand();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return $urandom & 32'h7FFF_FFFF;
    if (sel < 12) return 32'd0;
    if (sel < 16) return mod_m;
    if (sel < 20) return 2 * mod_m - 1;
    return $urandom_range(2 * mod_m - 1);
  endfunction

  function automatic logic [63:0] rand_plain();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return 64'($signed($urandom_range(200)) - 100);
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(input in_t it);
    pending_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_random(input int n);
    logic [3:0] fn;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(99) < 5) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
      push_item(make_item(fn, rand_operand(), rand_operand(), rand_plain()));
    end
  endtask

  // Waits until every beat has been taken and every result checked.
  task automatic drain();
    while (n_taken != n_queued || want_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] m);
    int c0;
    c0 = cfg_count;
    @(negedge clk);
    cfg_data <= m;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_count == c0);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] top;
    mod_m = {2'b00, RESET_MODULUS};
    derive_constants();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats at the reset modulus, no idling.
    top = 2 * mod_m - 1;
    push_item(make_item(FN_FROM_INT, 0, 0, 64'h8000_0000_0000_0000));
    push_item(make_item(FN_FROM_INT, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
    push_item(make_item(FN_FROM_INT, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    push_item(make_item(FN_FROM_INT, 0, 0, 64'd0));
    push_item(make_item(FN_TO_INT, top, 0, 0));
    push_item(make_item(FN_TO_INT, 32'h7FFF_FFFF, 0, 0));
    push_item(make_item(FN_NEG, 0, 0, 0));
    push_item(make_item(FN_NEG, top, 0, 0));
    push_item(make_item(FN_ADD, top, top, 0));
    push_item(make_item(FN_ADD, 0, 0, 0));
    push_item(make_item(FN_SUB, 0, top, 0));
    push_item(make_item(FN_SUB, 32'h7FFF_FFFF, 0, 0));
    push_item(make_item(FN_MUL, top, top, 0));
    push_item(make_item(FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    push_item(make_item(FN_INV, 0, 0, 0));
    push_item(make_item(FN_INV, mod_m, 0, 0));
    push_item(make_item(FN_INV, 12345, 0, 0));
    push_item(make_item(FN_DIV, top, 777, 0));
    push_item(make_item(FN_EQ, 5, mod_m + 5, 0));
    push_item(make_item(FN_EQ, 0, top, 0));
    push_item(make_item(FN_LT, 0, top, 0));
    push_item(make_item(FN_LT, top, 1, 0));
    push_item(make_item(FN_IS_ZERO, mod_m, 0, 0));
    push_item(make_item(FN_IS_ZERO, 1, 0, 0));
    push_item(make_item(4'd11, 1, 1, 64'd1));
    push_item(make_item(4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    drain();

    // Sender idles a little, receiver a lot.
    phase = 1;
    send_idle_pct = 11;
    recv_idle_pct = 55;
    write_modulus(30'd3);
    push_random(120);
    drain();
    write_modulus(30'($urandom_range(30'h3FFF_FFFF, 3) | 1));
    push_random(250);
    drain();

    // The other way round; the even write must leave the modulus alone.
    phase = 2;
    send_idle_pct = 55;
    recv_idle_pct = 11;
    write_modulus(30'($urandom_range(30'h3FFF_FFFE, 4) & 30'h3FFF_FFFE));
    write_modulus(30'h3FFF_FFFF);
    push_random(370);
    drain();

    // No idling, apart from the long hold-off; the tiny write is ignored.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_modulus(30'd1);
    write_modulus(RESET_MODULUS);
    phase = 3;
    push_random(340);
    drain();

    repeat (100) @(posedge clk);
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
